// ----- rtl/pose_velocity_estimator_defines.svh -----
// Assertion macros used by the top-level RTL.
`ifndef POSE_VELOCITY_ESTIMATOR_DEFINES_SVH
`define POSE_VELOCITY_ESTIMATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PVE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define PVE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/pve_pkg.sv -----
`default_nettype none
package pve_pkg;
	localparam int TICKS_PER_SECOND = 1000000;
	localparam int TPS_W  = $clog2(TICKS_PER_SECOND + 1);
	localparam int DIFF_W = 33;
	localparam int NUM_W  = DIFF_W + TPS_W;
	localparam int CNT_W  = $clog2(NUM_W);
	localparam int PROD_W = 50;
	localparam int ADDR_W = 3;
	localparam int FIFO_DEPTH = 2;

	localparam logic REG_MIN_INTERVAL = 1'b0;
	localparam logic REG_SMOOTHING    = 1'b1;

	typedef struct packed {
		logic               first;
		logic [31:0]        dt;
		logic signed [32:0] dx;
		logic signed [32:0] dy;
		logic signed [15:0] dh;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0]        h;
	} pve_item_t;
endpackage
`default_nettype wire

// ----- rtl/pve_front.sv -----
`default_nettype none
module pve_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic [31:0]         sample_time,
	input  wire logic signed [31:0]  pos_x,
	input  wire logic signed [31:0]  pos_y,
	input  wire logic [15:0]         heading,
	input  wire logic [31:0]         min_interval,
	input  wire logic                q_full,
	output logic                     q_push,
	output pve_pkg::pve_item_t       q_item
);
	logic        have_q;
	logic [31:0] prev_t_q;
	logic [31:0] prev_x_q;
	logic [31:0] prev_y_q;
	logic [15:0] prev_h_q;
	logic        acc;
	logic        drop;
	logic [31:0] dt;
	logic [15:0] dh;

	assign full = q_full;
	assign acc  = push && !q_full;
	assign dt   = sample_time - prev_t_q;
	assign dh   = heading - prev_h_q;
	// too close (or same tick) to the last kept sample
	assign drop = have_q && ((dt == 32'd0) || (dt < min_interval));
	assign q_push = acc && !drop;

	always_comb begin
		q_item.first = !have_q;
		q_item.dt    = dt;
		q_item.dx    = $signed({pos_x[31], pos_x}) - $signed({prev_x_q[31], prev_x_q});
		q_item.dy    = $signed({pos_y[31], pos_y}) - $signed({prev_y_q[31], prev_y_q});
		q_item.dh    = $signed(dh);
		q_item.x     = pos_x;
		q_item.y     = pos_y;
		q_item.h     = heading;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q   <= 1'b0;
			prev_t_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			prev_h_q <= '0;
		end else if (q_push) begin
			have_q   <= 1'b1;
			prev_t_q <= sample_time;
			prev_x_q <= pos_x;
			prev_y_q <= pos_y;
			prev_h_q <= heading;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/pve_fifo.sv -----
`default_nettype none
module pve_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr,
	input  wire pve_pkg::pve_item_t wdata,
	output logic                    full,
	input  wire logic               rd,
	output pve_pkg::pve_item_t      rdata,
	output logic                    empty
);
	localparam int PTR_W = $clog2(pve_pkg::FIFO_DEPTH);
	localparam int CW    = $clog2(pve_pkg::FIFO_DEPTH + 1);

	pve_pkg::pve_item_t slot_q [pve_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full  = (cnt_q == CW'(pve_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rdata = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PTR_W'(pve_pkg::FIFO_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PTR_W'(pve_pkg::FIFO_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/pve_back.sv -----
`default_nettype none
module pve_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_empty,
	input  wire pve_pkg::pve_item_t q_item,
	output logic                    q_pop,
	input  wire logic [17:0]        smoothing_coeff,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      out_x,
	output logic signed [31:0]      out_y,
	output logic [15:0]             out_heading,
	output logic signed [31:0]      vel_x,
	output logic signed [31:0]      vel_y,
	output logic signed [31:0]      yaw_rate
);
	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LOAD = 6'b000010,
		ST_DIV  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_ACC  = 6'b010000,
		ST_EMIT = 6'b100000
	} bst_t;

	localparam logic [1:0] AX_X   = 2'd0;
	localparam logic [1:0] AX_Y   = 2'd1;
	localparam logic [1:0] AX_YAW = 2'd2;

	bst_t                         state_q;
	pve_pkg::pve_item_t           item_q;
	logic [1:0]                   axis_q;
	logic [pve_pkg::NUM_W-1:0]    num_q;
	logic [31:0]                  rem_q;
	logic [pve_pkg::CNT_W-1:0]    cnt_q;
	logic                         neg_q;
	logic signed [pve_pkg::PROD_W-1:0] prod_a_q;
	logic signed [pve_pkg::PROD_W-1:0] prod_b_q;
	logic signed [31:0]           v_q [3];
	logic signed [31:0]           prev_v_q [3];
	logic                         out_valid_q;

	logic signed [32:0]           diff;
	logic [32:0]                  mag;
	logic [32:0]                  trial;
	logic                         ge;
	logic signed [31:0]           raw;
	logic [16:0]                  coef_a;
	logic [16:0]                  coef_b;
	logic signed [pve_pkg::PROD_W:0] sum;
	logic                         emit_fire;

	assign empty     = !out_valid_q;
	assign q_pop     = (state_q == ST_IDLE) && !q_empty;
	assign emit_fire = (state_q == ST_EMIT) && (!out_valid_q || pop);

	always_comb begin
		case (axis_q)
			AX_X:    diff = item_q.dx;
			AX_Y:    diff = item_q.dy;
			AX_YAW:  diff = 33'(item_q.dh);
			default: diff = '0;
		endcase
		mag = diff[32] ? (~diff + 33'd1) : diff;
	end

	// one restoring step per cycle; remainder always stays below dt
	assign trial = {rem_q, num_q[pve_pkg::NUM_W-1]};
	assign ge    = (trial >= {1'b0, item_q.dt});

	// quotient magnitude sits in num_q; truncation toward zero, then saturate
	always_comb begin
		if (!neg_q) begin
			raw = (|num_q[pve_pkg::NUM_W-1:31]) ? 32'sh7FFFFFFF : $signed(num_q[31:0]);
		end else if ((|num_q[pve_pkg::NUM_W-1:32]) || (num_q[31] && (|num_q[30:0]))) begin
			raw = 32'sh80000000;
		end else begin
			raw = -$signed(num_q[31:0]);
		end
		coef_a = (smoothing_coeff[17:16] == 2'b00) ? {1'b0, smoothing_coeff[15:0]} : 17'd0;
		coef_b = 17'h10000 - coef_a;
		sum    = (pve_pkg::PROD_W + 1)'(prod_a_q) + (pve_pkg::PROD_W + 1)'(prod_b_q)
			+ (pve_pkg::PROD_W + 1)'(32768);
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					item_q <= q_item;
					v_q[0] <= '0;
					v_q[1] <= '0;
					v_q[2] <= '0;
				end
			end
			ST_LOAD: begin
				neg_q <= diff[32];
				num_q <= pve_pkg::NUM_W'({{pve_pkg::TPS_W{1'b0}}, mag}
					* pve_pkg::NUM_W'(pve_pkg::TICKS_PER_SECOND));
				rem_q <= '0;
				cnt_q <= '0;
			end
			ST_DIV: begin
				rem_q <= ge ? 32'(trial - {1'b0, item_q.dt}) : trial[31:0];
				num_q <= {num_q[pve_pkg::NUM_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_MUL: begin
				prod_a_q <= pve_pkg::PROD_W'($signed({1'b0, coef_a}) * prev_v_q[axis_q]);
				prod_b_q <= pve_pkg::PROD_W'($signed({1'b0, coef_b}) * raw);
			end
			ST_ACC: begin
				v_q[axis_q] <= sum[47:16];
			end
			ST_EMIT: begin
				if (emit_fire) begin
					out_x       <= item_q.x;
					out_y       <= item_q.y;
					out_heading <= item_q.h;
					vel_x       <= v_q[0];
					vel_y       <= v_q[1];
					yaw_rate    <= v_q[2];
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			axis_q      <= AX_X;
			out_valid_q <= 1'b0;
			prev_v_q[0] <= '0;
			prev_v_q[1] <= '0;
			prev_v_q[2] <= '0;
		end else begin
			if (emit_fire) begin
				out_valid_q <= 1'b1;
				prev_v_q[0] <= v_q[0];
				prev_v_q[1] <= v_q[1];
				prev_v_q[2] <= v_q[2];
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						axis_q  <= AX_X;
						state_q <= q_item.first ? ST_EMIT : ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (cnt_q == pve_pkg::CNT_W'(pve_pkg::NUM_W - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					if (axis_q == AX_YAW) begin
						state_q <= ST_EMIT;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= ST_LOAD;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/pose_velocity_estimator.sv -----
// Channel   Handshake             Payload
// input     push / full           sample_time, pos_x, pos_y, heading
// result    pop / empty           out_x, out_y, out_heading, vel_x, vel_y, yaw_rate
// config    psel/penable/pwrite   paddr, pwdata, prdata (pready tied high)
//
// First sample after reset: no division; it passes the queue, IDLE and EMIT,
// and its velocities read as zero. Later samples: the shared one-bit-per-cycle
// divider runs 53 steps per axis after LOAD, then MUL and ACC smooth; three axes
// in turn. Dropped samples are accepted by the front but give no queue transfer.
// A two-entry queue between front and back and a result register let input
// transfers continue while a result waits. Reset clears pointers and valid flags.
`default_nettype none
`include "pose_velocity_estimator_defines.svh"
module pose_velocity_estimator (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire logic [31:0]                 sample_time,
	input  wire logic signed [31:0]          pos_x,
	input  wire logic signed [31:0]          pos_y,
	input  wire logic [15:0]                 heading,
	output logic                             empty,
	input  wire logic                        pop,
	output logic signed [31:0]               out_x,
	output logic signed [31:0]               out_y,
	output logic [15:0]                      out_heading,
	output logic signed [31:0]               vel_x,
	output logic signed [31:0]               vel_y,
	output logic signed [31:0]               yaw_rate,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pve_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [31:0]                 pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	logic [31:0]        min_interval_q;
	logic [17:0]        smoothing_q;
	logic               wr_en;
	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_empty;
	pve_pkg::pve_item_t q_wdata;
	pve_pkg::pve_item_t q_rdata;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_interval_q <= 32'd5000;
			smoothing_q    <= '0;
		end else if (wr_en) begin
			case (paddr[2])
				pve_pkg::REG_MIN_INTERVAL: min_interval_q <= pwdata;
				pve_pkg::REG_SMOOTHING:    smoothing_q    <= pwdata[17:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			pve_pkg::REG_MIN_INTERVAL: prdata = min_interval_q;
			pve_pkg::REG_SMOOTHING:    prdata = {14'd0, smoothing_q};
			default:                   prdata = '0;
		endcase
	end

	pve_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample_time  (sample_time),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.heading      (heading),
		.min_interval (min_interval_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_wdata)
	);

	pve_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	pve_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_empty         (q_empty),
		.q_item          (q_rdata),
		.q_pop           (q_pop),
		.smoothing_coeff (smoothing_q),
		.empty           (empty),
		.pop             (pop),
		.out_x           (out_x),
		.out_y           (out_y),
		.out_heading     (out_heading),
		.vel_x           (vel_x),
		.vel_y           (vel_y),
		.yaw_rate        (yaw_rate)
	);

	`PVE_ASSERT_NOW(a_pop_nonempty, q_pop, !q_empty, "back popped an empty queue")
	`PVE_ASSERT_NEXT(a_pop_single, q_pop, !q_pop, "back popped twice in a row")
	`PVE_ASSERT_NEXT(a_push_lands, q_push, !q_empty, "pushed item not in queue")
endmodule
`default_nettype wire
